// File: sv/pipt_pkg.sv
// Shared types, constants and reset map for the point-in-polygon test block.
package pipt_pkg;

  localparam int COORD_W   = 16;
  localparam int PROD_W    = 2 * (COORD_W + 1);
  // Highest cell count the row can have, and slots a load can address.
  localparam int CELL_CAP  = 16;
  localparam int STORE_CAP = 8;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [COORD_W:0]    diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [3:0]                 vcount_t;
  typedef logic [2:0]                 vidx_t;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  // Test point travelling down the cell row with the previous vertex and parity.
  typedef struct packed {
    logic   valid;
    coord_t tx;
    coord_t ty;
    coord_t px;
    coord_t py;
    logic   parity;
  } token_t;

  // Vertex write broadcast to all cells.
  typedef struct packed {
    logic   en;
    vidx_t  index;
    coord_t x;
    coord_t y;
  } vtx_wr_t;

  // Default map (-5,-5) (5,-5) (5,1) (1,1) (1,5) (-5,5) in Q8.8, zero elsewhere.
  function automatic coord_t def_x(input int k);
    coord_t v;
    case (k)
      0:       v = -16'sd1280;
      1:       v = 16'sd1280;
      2:       v = 16'sd1280;
      3:       v = 16'sd256;
      4:       v = 16'sd256;
      5:       v = -16'sd1280;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t def_y(input int k);
    coord_t v;
    case (k)
      0:       v = -16'sd1280;
      1:       v = -16'sd1280;
      2:       v = 16'sd256;
      3:       v = 16'sd256;
      4:       v = 16'sd1280;
      5:       v = 16'sd1280;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/pipt_cell.sv
// One cell of the ray-casting row: holds one vertex and tests one polygon edge.
module pipt_cell #(
  parameter int                 CELL_INDEX = 0,
  parameter bit                 HAS_STORE  = 1'b1,
  parameter logic signed [15:0] RST_X      = 16'sd0,
  parameter logic signed [15:0] RST_Y      = 16'sd0
) (
  input  logic              clk,
  input  logic              rst,
  input  pipt_pkg::vcount_t n_used,
  input  pipt_pkg::vtx_wr_t wr,
  input  pipt_pkg::token_t  tok_in,
  output pipt_pkg::token_t  tok_out,
  output pipt_pkg::coord_t  vx,
  output pipt_pkg::coord_t  vy
);
  import pipt_pkg::*;

  coord_t vx_q, vy_q;

  // vertex storage; cells past the loadable slots hold a zero vertex
  generate
    if (HAS_STORE) begin : g_store
      always_ff @(posedge clk) begin
        if (rst) begin
          vx_q <= RST_X;
          vy_q <= RST_Y;
        end else if (wr.en && wr.index == 3'(CELL_INDEX)) begin
          vx_q <= wr.x;
          vy_q <= wr.y;
        end
      end
    end else begin : g_zero
      assign vx_q = '0;
      assign vy_q = '0;
    end
  endgenerate

  assign vx = vx_q;
  assign vy = vy_q;

  // stage 1: straddle check, differences, two products
  coord_t tx, ty, px, py;
  diff_t  dy, dx_t, dx_j, dy_t;
  prod_t  lhs_c, rhs_c;
  logic   active, straddle;

  assign tx = tok_in.tx;
  assign ty = tok_in.ty;
  assign px = tok_in.px;
  assign py = tok_in.py;

  always_comb begin
    active   = tok_in.valid && (4'(CELL_INDEX) < n_used);
    straddle = (vy_q > ty) != (py > ty);
    dy       = {py[15], py} - {vy_q[15], vy_q};
    dx_t     = {tx[15], tx} - {vx_q[15], vx_q};
    dx_j     = {px[15], px} - {vx_q[15], vx_q};
    dy_t     = {ty[15], ty} - {vy_q[15], vy_q};
    lhs_c    = dx_t * dy;
    rhs_c    = dx_j * dy_t;
  end

  logic   s1_valid;
  logic   s1_cross_en, s1_dy_pos, s1_parity;
  prod_t  s1_lhs, s1_rhs;
  coord_t s1_tx, s1_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_cross_en <= active && straddle;
    s1_dy_pos   <= dy > 0;
    s1_lhs      <= lhs_c;
    s1_rhs      <= rhs_c;
    s1_tx       <= tx;
    s1_ty       <= ty;
    s1_parity   <= tok_in.parity;
  end

  // stage 2: compare, flipped for a downward edge, toggle parity
  logic crossed;
  assign crossed = s1_cross_en && (s1_dy_pos ? (s1_lhs < s1_rhs) : (s1_lhs > s1_rhs));

  always_ff @(posedge clk) begin
    tok_out.tx     <= s1_tx;
    tok_out.ty     <= s1_ty;
    tok_out.px     <= vx_q;
    tok_out.py     <= vy_q;
    tok_out.parity <= s1_parity ^ crossed;
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= s1_valid;
    end
  end

endmodule

// File: sv/point_in_polygon_test_top.sv
// Top level of the point-in-polygon test: control, vertex count and cell row.
//
// Even-odd ray casting against a polygon held in a row of cells, one vertex
// per cell. Input channel (in_valid/in_ready) carries one beat per item:
// action = load writes coord_x/coord_y into slot vertex_index and gives
// no result; action = test sends the point down the cell row.
// Each cell checks the edge to the previous vertex in two register stages;
// the row has NCELL = min(MAX_VERTICES, 16) cells. Only one point is in
// the row at a time: busy blocks the next item until the result leaves
// the row, and a full spare result register can also hold it off.
// Output channel (out_valid/out_ready) carries inside_res. The output
// register plus one spare result register let a new item be taken while
// a result waits; with both full, in_ready stays low until out_ready.
// cfg_we/cfg_wdata set vertex_count; the count in use is saturated to MAX_VERTICES.
// Reset (rst, synchronous) loads the default map into slots 0..5, zeroes
// the rest, sets vertex_count to 6 and empties the row and output.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [2:0]       vertex_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             inside_res
);
  import pipt_pkg::*;

  localparam int NCELL = (MAX_VERTICES < CELL_CAP) ? MAX_VERTICES : CELL_CAP;
  localparam int NSTORE = (MAX_VERTICES < STORE_CAP) ? MAX_VERTICES : STORE_CAP;

  // vertex count register
  vcount_t vertex_count, n_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 4'd6;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_comb begin
    if ({3'b000, vertex_count} > 7'(MAX_VERTICES)) begin
      n_used = 4'(MAX_VERTICES);
    end else begin
      n_used = vertex_count;
    end
  end

  // input handshake
  logic busy, pend_valid, pend_bit, in_acc;
  assign in_ready = !busy && !pend_valid;
  assign in_acc   = in_valid && in_ready;

  vtx_wr_t wr;
  assign wr.en    = in_acc && (action == ACT_LOAD);
  assign wr.index = vertex_index;
  assign wr.x     = coord_x;
  assign wr.y     = coord_y;

  // cell row
  token_t chain [NCELL+1];
  coord_t cell_vx [NCELL];
  coord_t cell_vy [NCELL];

  generate
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
      pipt_cell #(
        .CELL_INDEX (k),
        .HAS_STORE  (k < NSTORE),
        .RST_X      ((k < NSTORE) ? def_x(k) : 16'sd0),
        .RST_Y      ((k < NSTORE) ? def_y(k) : 16'sd0)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .n_used  (n_used),
        .wr      (wr),
        .tok_in  (chain[k]),
        .tok_out (chain[k+1]),
        .vx      (cell_vx[k]),
        .vy      (cell_vy[k])
      );
    end
  endgenerate

  // first edge closes the polygon: previous vertex is the last one in use
  coord_t last_x, last_y;
  vcount_t last_idx;
  assign last_idx = n_used - 4'd1;

  always_comb begin
    last_x = '0;
    last_y = '0;
    for (int k = 0; k < NCELL; k++) begin
      if (4'(k) == last_idx) begin
        last_x = cell_vx[k];
        last_y = cell_vy[k];
      end
    end
  end

  // head of the row
  token_t head;

  always_ff @(posedge clk) begin
    head.tx     <= coord_x;
    head.ty     <= coord_y;
    head.px     <= last_x;
    head.py     <= last_y;
    head.parity <= 1'b0;
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= in_acc && (action == ACT_TEST);
    end
  end

  assign chain[0] = head;

  // busy from test acceptance until its result leaves the row
  logic res_valid, res_bit;
  assign res_valid = chain[NCELL].valid;
  assign res_bit   = chain[NCELL].parity;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_acc && (action == ACT_TEST)) begin
      busy <= 1'b1;
    end else if (res_valid) begin
      busy <= 1'b0;
    end
  end

  // output register with one spare result register behind it
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        inside_res <= pend_bit;
        pend_valid <= res_valid;
        pend_bit   <= res_bit;
      end else begin
        out_valid  <= res_valid;
        inside_res <= res_bit;
      end
    end else if (res_valid) begin
      pend_valid <= 1'b1;
      pend_bit   <= res_bit;
    end
  end

endmodule
